// ===== rtl/wsms_pkg.sv =====
// Package with the request and response types and the security type decision logic.
`timescale 1ns / 1ps

package wsms_pkg;

    localparam int NUM_TYPES = 11;

    localparam logic [3:0] TYPE_NONE      = 4'd0;
    localparam logic [3:0] TYPE_SWEP      = 4'd1;
    localparam logic [3:0] TYPE_DWEP      = 4'd2;
    localparam logic [3:0] TYPE_LEAP      = 4'd3;
    localparam logic [3:0] TYPE_WPA_PSK   = 4'd4;
    localparam logic [3:0] TYPE_WPA_EAP   = 4'd5;
    localparam logic [3:0] TYPE_WPA2_PSK  = 4'd6;
    localparam logic [3:0] TYPE_WPA2_EAP  = 4'd7;
    localparam logic [3:0] TYPE_SAE       = 4'd8;
    localparam logic [3:0] TYPE_OWE       = 4'd9;
    localparam logic [3:0] TYPE_SUITEB192 = 4'd10;
    localparam logic [3:0] TYPE_UNKNOWN   = 4'd11;

    localparam int CAP_WEP40  = 0;
    localparam int CAP_WEP104 = 1;
    localparam int CAP_TKIP   = 2;
    localparam int CAP_CCMP   = 3;
    localparam int CAP_WPA    = 4;
    localparam int CAP_RSN    = 5;
    localparam int CAP_IBSS   = 6;

    localparam int FLG_PTKIP  = 2;
    localparam int FLG_PCCMP  = 3;
    localparam int FLG_PSK    = 8;
    localparam int FLG_8021X  = 9;
    localparam int FLG_SAE    = 10;
    localparam int FLG_OWE    = 11;
    localparam int FLG_OWETM  = 12;
    localparam int FLG_SB192  = 13;

    typedef struct packed {
        logic [6:0]  iface_caps;
        logic        have_ap;
        logic        adhoc;
        logic        ap_privacy;
        logic [13:0] ap_wpa_flags;
        logic [13:0] ap_rsn_flags;
        logic [3:0]  requested_type;
    } sel_req_t;

    typedef struct packed {
        logic [3:0]  best_type;
        logic        requested_valid;
        logic [10:0] valid_mask;
    } sel_rsp_t;

    function automatic logic ciphers_ok(input logic [6:0] caps, input logic [13:0] fl,
                                        input logic wep_only);
        logic [3:0] pair;
        logic [3:0] grp;
        pair = caps[3:0] & fl[3:0];
        grp  = caps[3:0] & fl[7:4];
        if (wep_only)
        begin
            return |grp[1:0];
        end
        return (|pair) && (|grp);
    endfunction

    function automatic logic psk_pair_ok(input logic [6:0] caps, input logic [13:0] fl,
                                         input logic km);
        return km && ((fl[FLG_PTKIP] && caps[CAP_TKIP]) ||
                      (fl[FLG_PCCMP] && caps[CAP_CCMP]));
    endfunction

    function automatic sel_rsp_t select_security(input sel_req_t r);
        logic [6:0]  caps;
        logic        ap;
        logic        adh;
        logic        priv;
        logic [13:0] wpa;
        logic [13:0] rsn;
        logic        wpa_nz;
        logic        rsn_nz;
        logic        wep_caps;
        logic        wep_ap_ok;
        logic [10:0] mask;
        logic [15:0] mask_ext;
        sel_rsp_t    rsp;

        caps     = r.iface_caps;
        ap       = r.have_ap;
        adh      = r.adhoc;
        priv     = r.ap_privacy;
        wpa      = r.ap_wpa_flags;
        rsn      = r.ap_rsn_flags;
        wpa_nz   = |wpa;
        rsn_nz   = |rsn;
        wep_caps = caps[CAP_WEP40] | caps[CAP_WEP104];

        wep_ap_ok = priv && ((wpa_nz || rsn_nz) ?
                    (ciphers_ok(caps, wpa, 1'b1) || ciphers_ok(caps, rsn, 1'b1)) : 1'b1);

        mask[TYPE_NONE] = !ap ? 1'b1 : (!priv && !wpa_nz && !rsn_nz);
        mask[TYPE_SWEP] = !ap ? wep_caps : wep_ap_ok;
        mask[TYPE_LEAP] = adh ? 1'b0 : (!ap ? wep_caps : wep_ap_ok);
        if (!ap && !adh)
        begin
            mask[TYPE_DWEP] = wep_caps;
        end
        else if (adh || rsn_nz || !priv)
        begin
            mask[TYPE_DWEP] = 1'b0;
        end
        else
        begin
            mask[TYPE_DWEP] = wpa_nz ? (wpa[FLG_8021X] && ciphers_ok(caps, wpa, 1'b0)) : 1'b1;
        end

        mask[TYPE_WPA_PSK] = !adh && caps[CAP_WPA] &&
                             (ap ? psk_pair_ok(caps, wpa, wpa[FLG_PSK]) : 1'b1);
        mask[TYPE_WPA_EAP] = !adh && caps[CAP_WPA] &&
                             (ap ? (wpa[FLG_8021X] && ciphers_ok(caps, wpa, 1'b0)) : 1'b1);

        mask[TYPE_WPA2_PSK] = caps[CAP_RSN] && (!ap ? 1'b1 :
            (adh ? (caps[CAP_IBSS] && rsn[FLG_PCCMP] && caps[CAP_CCMP]) :
                   psk_pair_ok(caps, rsn, rsn[FLG_PSK])));
        mask[TYPE_SAE] = caps[CAP_RSN] && (!ap ? 1'b1 :
            (adh ? (caps[CAP_IBSS] && rsn[FLG_PCCMP] && caps[CAP_CCMP]) :
                   psk_pair_ok(caps, rsn, rsn[FLG_SAE])));

        mask[TYPE_WPA2_EAP] = !adh && caps[CAP_RSN] &&
                              (ap ? (rsn[FLG_8021X] && ciphers_ok(caps, rsn, 1'b0)) : 1'b1);
        mask[TYPE_OWE] = !adh && caps[CAP_RSN] &&
                         (ap ? (rsn[FLG_OWE] || rsn[FLG_OWETM]) : 1'b1);
        mask[TYPE_SUITEB192] = !adh && caps[CAP_RSN] && (ap ? rsn[FLG_SB192] : 1'b1);

        if (mask[TYPE_SUITEB192])
        begin
            rsp.best_type = TYPE_SUITEB192;
        end
        else if (mask[TYPE_SAE])
        begin
            rsp.best_type = TYPE_SAE;
        end
        else if (mask[TYPE_WPA2_EAP])
        begin
            rsp.best_type = TYPE_WPA2_EAP;
        end
        else if (mask[TYPE_WPA2_PSK])
        begin
            rsp.best_type = TYPE_WPA2_PSK;
        end
        else if (mask[TYPE_WPA_EAP])
        begin
            rsp.best_type = TYPE_WPA_EAP;
        end
        else if (mask[TYPE_WPA_PSK])
        begin
            rsp.best_type = TYPE_WPA_PSK;
        end
        else if (mask[TYPE_SWEP])
        begin
            rsp.best_type = TYPE_SWEP;
        end
        else if (mask[TYPE_DWEP])
        begin
            rsp.best_type = TYPE_DWEP;
        end
        else if (mask[TYPE_LEAP])
        begin
            rsp.best_type = TYPE_LEAP;
        end
        else if (mask[TYPE_OWE])
        begin
            rsp.best_type = TYPE_OWE;
        end
        else if (mask[TYPE_NONE])
        begin
            rsp.best_type = TYPE_NONE;
        end
        else
        begin
            rsp.best_type = TYPE_UNKNOWN;
        end

        // Codes above the last defined type read zero bits of the widened mask.
        mask_ext            = {5'b0, mask};
        rsp.requested_valid = mask_ext[r.requested_type];
        rsp.valid_mask      = mask;
        return rsp;
    endfunction

endpackage

// ===== rtl/wifi_security_mode_select.sv =====
// Top level of the wireless security type selector.
//
//   Channel   Handshake          Payload
//   request   start, busy        req  (sel_req_t)
//   response  done               rsp  (sel_rsp_t)
//
// A transaction is taken at every clock edge with start high; busy stays low.
// Done comes from the output valid register, fed by the input valid register, and marks when rsp holds the result.
// The request is held in an input register and the decision logic feeds the response register.
// Reset clears both valid flags; the receiver cannot stall, so nothing is ever held back.
`timescale 1ns / 1ps

module wifi_security_mode_select
    import wsms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  sel_req_t req,
    output logic     done,
    output sel_rsp_t rsp
);

    logic     in_valid_reg;
    sel_req_t in_data_reg;
    logic     out_valid_reg;
    sel_rsp_t out_data_reg;
    sel_rsp_t out_data_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_data_reg <= req;
        end
        if (in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        out_data_next = select_security(in_data_reg);
    end

    assign done = out_valid_reg;
    assign rsp  = out_data_reg;

endmodule

// ===== rtl/wsms_checker.sv =====
// Port-level checker for the security type selector and its bind.
`timescale 1ns / 1ps

module wsms_checker
    import wsms_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input sel_req_t req,
    input logic     done,
    input sel_rsp_t rsp
);

    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy, 2) && $past(rst_n, 2) && $past(rst_n, 1) |-> done)
        else $error("Accepted transaction produced no response.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("Response without a matching transaction.");

    a_best_none: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((rsp.best_type == TYPE_UNKNOWN) == (rsp.valid_mask == 11'd0)))
        else $error("Best type disagrees with the validity mask.");

    a_req_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.requested_valid |->
            ({5'b0, rsp.valid_mask} >> $past(req.requested_type, 2)) != 16'd0 &&
            $past(req.requested_type, 2) < TYPE_UNKNOWN)
        else $error("Requested type flagged usable but not in the mask.");

endmodule

bind wifi_security_mode_select wsms_checker u_wsms_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);
